### rtl/bchd_pkg.sv
// Shared types, constants and helper functions of the button click and hold detector.
package bchd_pkg;

  localparam int TIME_WIDTH  = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int CMP_WIDTH   = (TIME_WIDTH > LIMIT_WIDTH) ? TIME_WIDTH : LIMIT_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [LIMIT_WIDTH-1:0] limit_t;

  typedef enum logic [2:0] {
    MODE_IDLE           = 3'd0,
    MODE_CHECK_ACTIVE   = 3'd1,
    MODE_CHECK_INACTIVE = 3'd2,
    MODE_HOLD           = 3'd3,
    MODE_CHECK_RELEASE  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SINGLE  = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_HOLD    = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ACTIVE_LEVEL   = 3'd0,
    CFG_DEBOUNCE_TICKS = 3'd1,
    CFG_PRESS_LIMIT    = 3'd2,
    CFG_GAP_LIMIT      = 3'd3,
    CFG_HOLD_LIMIT     = 3'd4,
    CFG_RELEASE_LIMIT  = 3'd5
  } cfg_idx_t;

  localparam logic   RST_ACTIVE_LEVEL   = 1'b0;
  localparam limit_t RST_DEBOUNCE_TICKS = LIMIT_WIDTH'(50);
  localparam limit_t RST_PRESS_LIMIT    = LIMIT_WIDTH'(500);
  localparam limit_t RST_GAP_LIMIT      = LIMIT_WIDTH'(300);
  localparam limit_t RST_HOLD_LIMIT     = LIMIT_WIDTH'(3000);
  localparam limit_t RST_RELEASE_LIMIT  = LIMIT_WIDTH'(300);

  typedef struct packed {
    logic   active_level;
    limit_t debounce_ticks;
    limit_t press_limit;
    limit_t gap_limit;
    limit_t hold_limit;
    limit_t release_limit;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    time_t change_elapsed;
    logic  clicks_seen;
  } fsm_state_t;

  function automatic time_t sat_inc(time_t v);
    return (v == '1) ? v : v + time_t'(1);
  endfunction

  function automatic logic time_lt(time_t t, limit_t l);
    return CMP_WIDTH'(t) < CMP_WIDTH'(l);
  endfunction

  function automatic logic time_eq(time_t t, limit_t l);
    return CMP_WIDTH'(t) == CMP_WIDTH'(l);
  endfunction

endpackage

### rtl/bchd_if.sv
// Valid/ready channel interfaces for tick items and detector results.
interface bchd_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic edge_req;

  modport source(output valid, output pin_level, output edge_req, input ready);
  modport sink(input valid, input pin_level, input edge_req, output ready);
endinterface

interface bchd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       clean_level;

  modport source(output valid, output event_res, output clean_level, input ready);
  modport sink(input valid, input event_res, input clean_level, output ready);
endinterface

### rtl/button_click_hold_detector_unit.sv
// Top level of the button debounce and click, double click, hold and release detector.
// Usage: each transfer on in_tick is one millisecond tick carrying the raw pin level
// and an edge interrupt flag. Every tick produces exactly one transfer on out_res,
// carrying the event code (none, single click, double click, hold, release) and
// the debounced pin level after that tick.
// The result of an accepted tick is registered and is valid in the cycle after it is taken.
// Throughput is one tick per cycle while the receiver takes each result; the debounce,
// timer and mode update is one pass of compare logic between the state and result registers.
// The result register acts as the output stage: in_tick stays ready while the
// result is empty or being taken in the same cycle, so a stalled receiver holds
// the result and blocks further ticks until it is taken, and nothing is lost.
// Configuration is written through cfg_we, cfg_index and cfg_data while no tick
// is in flight; indexes beyond the register list are ignored.
// Synchronous active-low reset loads the register defaults, clears the timers,
// sets the debounced level to the released level and empties the result stage.
module button_click_hold_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bchd_in_if.sink                              in_tick,
  bchd_out_if.source                           out_res,
  input  logic                                 cfg_we,
  input  logic [bchd_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [bchd_pkg::LIMIT_WIDTH-1:0]     cfg_data
);

  bchd_pkg::cfg_t       cfg_r;
  logic                 deb_busy_r;
  bchd_pkg::time_t      deb_elapsed_r;
  logic                 stable_r;
  bchd_pkg::fsm_state_t fsm_r;
  logic                 out_valid_r;
  bchd_pkg::event_t     event_r;

  logic                 deb_busy_nxt;
  bchd_pkg::time_t      deb_elapsed_nxt;
  logic                 stable_nxt;
  bchd_pkg::fsm_state_t fsm_cur;
  bchd_pkg::fsm_state_t fsm_nxt;
  bchd_pkg::event_t     event_nxt;
  logic                 in_fire;

  assign in_tick.ready = !out_valid_r || out_res.ready;
  assign in_fire       = in_tick.valid && in_tick.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level   <= bchd_pkg::RST_ACTIVE_LEVEL;
      cfg_r.debounce_ticks <= bchd_pkg::RST_DEBOUNCE_TICKS;
      cfg_r.press_limit    <= bchd_pkg::RST_PRESS_LIMIT;
      cfg_r.gap_limit      <= bchd_pkg::RST_GAP_LIMIT;
      cfg_r.hold_limit     <= bchd_pkg::RST_HOLD_LIMIT;
      cfg_r.release_limit  <= bchd_pkg::RST_RELEASE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        bchd_pkg::CFG_ACTIVE_LEVEL:   cfg_r.active_level   <= cfg_data[0];
        bchd_pkg::CFG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_data;
        bchd_pkg::CFG_PRESS_LIMIT:    cfg_r.press_limit    <= cfg_data;
        bchd_pkg::CFG_GAP_LIMIT:      cfg_r.gap_limit      <= cfg_data;
        bchd_pkg::CFG_HOLD_LIMIT:     cfg_r.hold_limit     <= cfg_data;
        bchd_pkg::CFG_RELEASE_LIMIT:  cfg_r.release_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    deb_busy_nxt    = deb_busy_r;
    deb_elapsed_nxt = bchd_pkg::sat_inc(deb_elapsed_r);
    stable_nxt      = stable_r;
    if (in_tick.edge_req && !deb_busy_r) begin
      deb_busy_nxt    = 1'b1;
      deb_elapsed_nxt = '0;
    end
    if (deb_busy_nxt && !bchd_pkg::time_lt(deb_elapsed_nxt, cfg_r.debounce_ticks)) begin
      stable_nxt   = in_tick.pin_level;
      deb_busy_nxt = 1'b0;
    end
    fsm_cur                = fsm_r;
    fsm_cur.change_elapsed = bchd_pkg::sat_inc(fsm_r.change_elapsed);
  end

  bchd_mode_fsm u_mode_fsm (
    .cur     (fsm_cur),
    .pressed (stable_nxt == cfg_r.active_level),
    .cfg     (cfg_r),
    .nxt     (fsm_nxt),
    .evt     (event_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_busy_r          <= 1'b0;
      deb_elapsed_r       <= '0;
      stable_r            <= !bchd_pkg::RST_ACTIVE_LEVEL;
      fsm_r.mode          <= bchd_pkg::MODE_IDLE;
      fsm_r.change_elapsed <= '0;
      fsm_r.clicks_seen   <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        deb_busy_r    <= deb_busy_nxt;
        deb_elapsed_r <= deb_elapsed_nxt;
        stable_r      <= stable_nxt;
        fsm_r         <= fsm_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_r <= event_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.event_res   = event_r;
  assign out_res.clean_level = stable_r;

endmodule

### rtl/bchd_mode_fsm.sv
// Next-state and event logic of the click, double click, hold and release machine.
module bchd_mode_fsm (
  input  bchd_pkg::fsm_state_t cur,
  input  logic                 pressed,
  input  bchd_pkg::cfg_t       cfg,
  output bchd_pkg::fsm_state_t nxt,
  output bchd_pkg::event_t     evt
);

  always_comb begin
    bchd_pkg::time_t el;
    el  = cur.change_elapsed;
    nxt = cur;
    evt = bchd_pkg::EV_NONE;
    case (cur.mode)
      bchd_pkg::MODE_CHECK_ACTIVE: begin
        if (!pressed) begin
          if (bchd_pkg::time_lt(el, cfg.press_limit)) begin
            nxt.mode           = bchd_pkg::MODE_CHECK_INACTIVE;
            nxt.change_elapsed = '0;
          end else begin
            nxt.mode = bchd_pkg::MODE_IDLE;
          end
        end else if (!bchd_pkg::time_lt(el, cfg.hold_limit)) begin
          nxt.mode        = bchd_pkg::MODE_HOLD;
          nxt.clicks_seen = 1'b0;
          evt             = bchd_pkg::EV_HOLD;
        end
      end
      bchd_pkg::MODE_CHECK_INACTIVE: begin
        if (!pressed && !bchd_pkg::time_lt(el, cfg.gap_limit)) begin
          nxt.mode = bchd_pkg::MODE_IDLE;
          if (cur.clicks_seen) begin
            nxt.clicks_seen = 1'b0;
            evt             = bchd_pkg::EV_DOUBLE;
          end else begin
            evt = bchd_pkg::EV_SINGLE;
          end
        end else if (pressed) begin
          nxt.mode           = bchd_pkg::MODE_CHECK_ACTIVE;
          nxt.change_elapsed = '0;
          if (bchd_pkg::time_lt(el, cfg.gap_limit)) begin
            nxt.clicks_seen = 1'b1;
          end else if (bchd_pkg::time_eq(el, cfg.gap_limit)) begin
            if (cur.clicks_seen) begin
              nxt.clicks_seen = 1'b0;
              evt             = bchd_pkg::EV_DOUBLE;
            end else begin
              evt = bchd_pkg::EV_SINGLE;
            end
          end
        end
      end
      bchd_pkg::MODE_HOLD: begin
        if (!pressed) begin
          nxt.mode           = bchd_pkg::MODE_CHECK_RELEASE;
          nxt.change_elapsed = '0;
        end
      end
      bchd_pkg::MODE_CHECK_RELEASE: begin
        if (!pressed && !bchd_pkg::time_lt(el, cfg.release_limit)) begin
          nxt.mode = bchd_pkg::MODE_IDLE;
          evt      = bchd_pkg::EV_RELEASE;
        end else if (pressed) begin
          if (bchd_pkg::time_eq(el, cfg.release_limit)) begin
            evt = bchd_pkg::EV_RELEASE;
          end
          nxt.mode           = bchd_pkg::MODE_CHECK_ACTIVE;
          nxt.change_elapsed = '0;
        end
      end
      default: begin
        nxt.mode = bchd_pkg::MODE_IDLE;
        if (pressed) begin
          nxt.mode           = bchd_pkg::MODE_CHECK_ACTIVE;
          nxt.change_elapsed = '0;
        end
      end
    endcase
  end

endmodule
